/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the edit overlay sampler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define EBS_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the next cycle.
`define EBS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/ebs_pkg.sv */
// Shared types and constants of the edit overlay B-spline sampler.
package ebs_pkg;

   localparam int GRID_AXIS_BITS_DEF = 4;
   localparam int FRAC_BITS_DEF      = 8;
   localparam int FRAC_FIELD_BITS    = 8;
   localparam int TAPS               = 4;
   localparam int TAP_BITS           = 2;
   localparam int NBR_BITS           = 6;
   localparam int W_BITS             = 15;
   localparam int M_BITS             = 17;
   localparam int RECIP3             = 43691;
   localparam int RECIP3_SHIFT       = 17;
   localparam int WXY_BITS           = 30;
   localparam int WXYZ_BITS          = 45;
   localparam int WROUND_SHIFT       = 29;
   localparam int WQ_BITS            = 17;
   localparam int WEIGHT_SKIP        = 6;
   localparam int PROD_BITS          = 34;
   localparam int ACC_BITS           = 40;
   localparam int REL_BITS           = 18;
   localparam int SUM_BITS           = 26;

   typedef enum logic [1:0] {
      FUNC_WRITE  = 2'd0,
      FUNC_INT    = 2'd1,
      FUNC_SPLINE = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      CSR_ORIGIN_X = 2'd0,
      CSR_ORIGIN_Y = 2'd1,
      CSR_ORIGIN_Z = 2'd2
   } csr_index_type;

   typedef logic [TAPS-1:0][W_BITS-1:0] weight_vec_type;

   typedef struct packed {
      logic              present;
      logic signed [15:0] delta;
      logic [7:0]        material;
   } cell_type;

endpackage

/* hw/rtl/ebs_ram.sv */
// Generic single-port synchronous RAM with registered read data.
module ebs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata <= mem_ff[addr];
   end

endmodule

/* hw/rtl/ebs_weight_unit.sv */
// Pipelined cubic B-spline weight generator for the three axes.
module ebs_weight_unit import ebs_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [2:0][FRAC_FIELD_BITS-1:0]     frac,
   output logic                                done,
   output weight_vec_type [2:0]                weights
);

   localparam int F  = FRAC_BITS;
   localparam int RW = 3 * F + 4;
   localparam int NW = RW + 16;
   localparam int SH = 3 * F + 1;
   localparam logic [RW-1:0] S3  = RW'(1) << (3 * F);
   localparam logic [NW-1:0] S3N = NW'(1) << (3 * F);

   logic [4:0] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[3:0], start};
      end
   end

   assign done = vld_ff[4];

   for (genvar a = 0; a < 3; a++) begin : g_axis
      logic [F+FRAC_FIELD_BITS-1:0] ext;
      logic [F-1:0]   u1_ff, u2k_ff, u3k_ff;
      logic [F:0]     v1_ff, v2k_ff;
      logic [2*F-1:0] uu2_ff, uu3_ff;
      logic [2*F+1:0] vv2_ff;
      logic [3*F-1:0] uuu3_ff;
      logic [3*F+2:0] vvv3_ff;
      logic [TAPS-1:0][RW-1:0]     raw;
      logic [TAPS-1:0][M_BITS-1:0] m_in;
      logic [TAPS-1:0][M_BITS-1:0] m_ff;

      assign ext = (F + FRAC_FIELD_BITS)'(frac[a]);

      always_comb begin
         logic [NW-1:0] n;
         raw[0] = RW'(vvv3_ff);
         raw[1] = RW'(3) * RW'(uuu3_ff) - RW'(6) * (RW'(uu3_ff) << F) + RW'(4) * S3;
         raw[2] = S3 + RW'(3) * (RW'(uu3_ff) << F) + RW'(3) * (RW'(u3k_ff) << (2 * F))
                  - RW'(3) * RW'(uuu3_ff);
         raw[3] = RW'(uuu3_ff);
         for (int t = 0; t < TAPS; t++) begin
            n       = (NW'(raw[t]) << 15) + NW'(3) * S3N;
            m_in[t] = M_BITS'(n >> SH);
         end
      end

      always_ff @(posedge clock) begin
         u1_ff   <= ext[F-1:0];
         v1_ff   <= ((F + 1)'(1) << F) - (F + 1)'(ext[F-1:0]);
         uu2_ff  <= (2 * F)'(u1_ff) * (2 * F)'(u1_ff);
         vv2_ff  <= (2 * F + 2)'(v1_ff) * (2 * F + 2)'(v1_ff);
         u2k_ff  <= u1_ff;
         v2k_ff  <= v1_ff;
         uuu3_ff <= (3 * F)'(uu2_ff) * (3 * F)'(u2k_ff);
         vvv3_ff <= (3 * F + 3)'(vv2_ff) * (3 * F + 3)'(v2k_ff);
         uu3_ff  <= uu2_ff;
         u3k_ff  <= u2k_ff;
         m_ff    <= m_in;
         for (int t = 0; t < TAPS; t++) begin
            weights[a][t] <= W_BITS'(((M_BITS + 17)'(m_ff[t]) * (M_BITS + 17)'(RECIP3))
                                     >> RECIP3_SHIFT);
         end
      end
   end

endmodule

/* hw/rtl/edit_overlay_bspline_sampler.sv */
// Top level of the density edit overlay with tricubic B-spline sampling.
// Throughput: one item at a time; a spline sample makes 64 neighbor reads
// from the single edit memory port, one per cycle, between weight set-up and drain.
// Reset clears the origin registers and then sweeps the edit memory to absent,
// one entry per cycle (4096 entries by default), before the first request transfer.
module edit_overlay_bspline_sampler import ebs_pkg::*; #(
   parameter int GRID_AXIS_BITS = GRID_AXIS_BITS_DEF,
   parameter int FRAC_BITS      = FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_func,
   input  logic signed [15:0] req_coord_x,
   input  logic signed [15:0] req_coord_y,
   input  logic signed [15:0] req_coord_z,
   input  logic [7:0]         req_frac_x,
   input  logic [7:0]         req_frac_y,
   input  logic [7:0]         req_frac_z,
   input  logic signed [15:0] req_base_density,
   input  logic [7:0]         req_base_material,
   input  logic signed [15:0] req_edit_delta,
   input  logic [7:0]         req_edit_material,
   input  logic               req_edit_present,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_density,
   output logic [7:0]         rsp_material,
   output logic               rsp_edit_found,
   output logic               rsp_saturated,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_data
);

`include "assert_macros.svh"

   localparam int G     = GRID_AXIS_BITS;
   localparam int AW    = 3 * G;
   localparam int CELLS = 1 << AW;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_LOOKUP, ST_WSETUP, ST_SCAN, ST_DRAIN, ST_FINISH
   } state_type;

   state_type state_ff;
   logic      done_pend_ff;

   logic [AW-1:0] clr_cnt_ff;
   logic signed [15:0] org_x_ff, org_y_ff, org_z_ff;

   func_type func_ff;
   logic [REL_BITS-1:0] rel_x_ff, rel_y_ff, rel_z_ff;
   logic [2:0][FRAC_FIELD_BITS-1:0] frac_ff;
   logic signed [15:0] base_ff, delta_ff;
   logic [7:0] base_mat_ff, edit_mat_ff;
   logic       edit_present_ff;

   logic signed [15:0] res_density_ff;
   logic [7:0]         res_material_ff;
   logic               res_found_ff, res_sat_ff;
   logic               rsp_valid_ff;
   logic signed [15:0] rsp_density_ff;
   logic [7:0]         rsp_material_ff;
   logic               rsp_found_ff, rsp_sat_ff;

   logic w_start_ff, w_done;
   weight_vec_type [2:0] weights;

   logic [NBR_BITS-1:0] scan_cnt_ff;
   logic p1_vld_ff, p1_in_ff, p2_vld_ff, p2_in_ff, p3_use_ff, p4_use_ff;
   logic [WXY_BITS-1:0]  p1_wxy_ff;
   logic [W_BITS-1:0]    p1_wz_ff;
   logic [WXYZ_BITS-1:0] p2_wxyz_ff;
   cell_type             p2_cell_ff;
   logic [WQ_BITS-1:0]   p2_w, p3_w_ff, best_w_ff;
   logic signed [15:0]   p3_delta_ff;
   logic [7:0]           p3_mat_ff, best_mat_ff;
   logic signed [PROD_BITS-1:0] p4_prod_ff;
   logic signed [ACC_BITS-1:0]  acc_ff;
   logic                        found_ff;

   logic           mem_we;
   logic [AW-1:0]  mem_addr;
   cell_type       mem_wdata, mem_rdata;
   logic [$bits(cell_type)-1:0] mem_rbits;

   logic [REL_BITS-1:0] nx, ny, nz;
   logic                scan_in, ctr_in;
   logic [AW-1:0]       scan_addr, ctr_addr;
   logic [WXYZ_BITS:0]  wxyz_rnd;
   logic signed [ACC_BITS-1:0] acc_rnd;
   logic signed [SUM_BITS-1:0] fin_sum, lk_sum;

   function automatic logic in_grid(logic [REL_BITS-1:0] n);
      return n[REL_BITS-1:G] == '0;
   endfunction

   function automatic logic [AW-1:0] cell_addr(logic [REL_BITS-1:0] x,
                                                logic [REL_BITS-1:0] y,
                                                logic [REL_BITS-1:0] z);
      return {z[G-1:0], y[G-1:0], x[G-1:0]};
   endfunction

   function automatic logic [REL_BITS-1:0] rel_of(logic signed [15:0] c,
                                                  logic signed [15:0] o);
      return REL_BITS'(c) - REL_BITS'(o);
   endfunction

   function automatic logic is_sat(logic signed [SUM_BITS-1:0] v);
      return (v > SUM_BITS'(32767)) || (v < -SUM_BITS'(32768));
   endfunction

   function automatic logic signed [15:0] clip16(logic signed [SUM_BITS-1:0] v);
      logic signed [15:0] r;
      if (v > SUM_BITS'(32767)) begin
         r = 16'sh7fff;
      end else if (v < -SUM_BITS'(32768)) begin
         r = 16'sh8000;
      end else begin
         r = 16'(v);
      end
      return r;
   endfunction

   function automatic logic [7:0] pick_mat(logic signed [15:0] d, logic [7:0] em,
                                           logic [7:0] bm);
      logic [7:0] r;
      if (d <= 16'sd0) begin
         r = 8'd0;
      end else if (em != 8'd0) begin
         r = em;
      end else begin
         r = (bm > 8'd1) ? bm : 8'd1;
      end
      return r;
   endfunction

   ebs_weight_unit #(.FRAC_BITS(FRAC_BITS)) u_weights (
      .clock   (clock),
      .reset   (reset),
      .start   (w_start_ff),
      .frac    (frac_ff),
      .done    (w_done),
      .weights (weights)
   );

   ebs_ram #(.WIDTH($bits(cell_type)), .DEPTH(CELLS)) u_grid (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rbits)
   );

   assign mem_rdata = cell_type'(mem_rbits);

   always_comb begin
      nx = rel_x_ff + REL_BITS'(scan_cnt_ff[1:0]) - REL_BITS'(1);
      ny = rel_y_ff + REL_BITS'(scan_cnt_ff[3:2]) - REL_BITS'(1);
      nz = rel_z_ff + REL_BITS'(scan_cnt_ff[5:4]) - REL_BITS'(1);
      scan_in   = in_grid(nx) && in_grid(ny) && in_grid(nz);
      scan_addr = cell_addr(nx, ny, nz);
      ctr_in    = in_grid(rel_x_ff) && in_grid(rel_y_ff) && in_grid(rel_z_ff);
      ctr_addr  = cell_addr(rel_x_ff, rel_y_ff, rel_z_ff);
      wxyz_rnd  = (WXYZ_BITS + 1)'(p2_wxyz_ff) + ((WXYZ_BITS + 1)'(1) << (WROUND_SHIFT - 1));
      p2_w      = wxyz_rnd[WXYZ_BITS:WROUND_SHIFT];
      acc_rnd   = acc_ff + ACC_BITS'(32768);
      fin_sum   = SUM_BITS'(base_ff) + SUM_BITS'(acc_rnd >>> 16);
      lk_sum    = SUM_BITS'(base_ff) + SUM_BITS'(mem_rdata.delta);
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_addr  = scan_addr;
      mem_wdata = '0;
      case (state_ff)
         ST_CLEAR: begin
            mem_we   = 1'b1;
            mem_addr = clr_cnt_ff;
         end
         ST_DISPATCH: begin
            mem_addr = ctr_addr;
            if (func_ff == FUNC_WRITE && ctr_in) begin
               mem_we = 1'b1;
               if (edit_present_ff) begin
                  mem_wdata = '{present: 1'b1, delta: delta_ff, material: edit_mat_ff};
               end
            end
         end
         default: begin
            mem_addr = scan_addr;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         org_x_ff     <= '0;
         org_y_ff     <= '0;
         org_z_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         done_pend_ff <= 1'b0;
         w_start_ff   <= 1'b0;
         p1_vld_ff    <= 1'b0;
         p2_vld_ff    <= 1'b0;
         p3_use_ff    <= 1'b0;
         p4_use_ff    <= 1'b0;
         scan_cnt_ff  <= '0;
      end else begin
         w_start_ff <= (state_ff == ST_DISPATCH) && (func_ff == FUNC_SPLINE);

         if (csr_valid) begin
            case (csr_index_type'(csr_index))
               CSR_ORIGIN_X: org_x_ff <= csr_data;
               CSR_ORIGIN_Y: org_y_ff <= csr_data;
               CSR_ORIGIN_Z: org_z_ff <= csr_data;
               default: ;
            endcase
         end

         if (done_pend_ff && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff    <= 1'b1;
            rsp_density_ff  <= res_density_ff;
            rsp_material_ff <= res_material_ff;
            rsp_found_ff    <= res_found_ff;
            rsp_sat_ff      <= res_sat_ff;
            done_pend_ff    <= 1'b0;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         p1_vld_ff  <= state_ff == ST_SCAN;
         p1_in_ff   <= scan_in;
         p1_wxy_ff  <= WXY_BITS'(weights[0][scan_cnt_ff[1:0]]) *
                       WXY_BITS'(weights[1][scan_cnt_ff[3:2]]);
         p1_wz_ff   <= weights[2][scan_cnt_ff[5:4]];
         p2_vld_ff  <= p1_vld_ff;
         p2_in_ff   <= p1_in_ff;
         p2_wxyz_ff <= WXYZ_BITS'(p1_wxy_ff) * WXYZ_BITS'(p1_wz_ff);
         p2_cell_ff <= mem_rdata;
         p3_use_ff  <= p2_vld_ff && p2_in_ff && p2_cell_ff.present &&
                       (p2_w > WQ_BITS'(WEIGHT_SKIP));
         p3_w_ff     <= p2_w;
         p3_delta_ff <= p2_cell_ff.delta;
         p3_mat_ff   <= p2_cell_ff.material;
         p4_use_ff   <= p3_use_ff;
         p4_prod_ff  <= PROD_BITS'(p3_delta_ff) * PROD_BITS'($signed({1'b0, p3_w_ff}));
         if (p3_use_ff) begin
            found_ff <= 1'b1;
            if (p3_mat_ff != 8'd0 && p3_w_ff > best_w_ff) begin
               best_w_ff   <= p3_w_ff;
               best_mat_ff <= p3_mat_ff;
            end
         end
         if (p4_use_ff) begin
            acc_ff <= acc_ff + ACC_BITS'(p4_prod_ff);
         end

         case (state_ff)
            ST_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + AW'(1);
               if (&clr_cnt_ff) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_valid && req_ready) begin
                  func_ff         <= func_type'(req_func);
                  rel_x_ff        <= rel_of(req_coord_x, org_x_ff);
                  rel_y_ff        <= rel_of(req_coord_y, org_y_ff);
                  rel_z_ff        <= rel_of(req_coord_z, org_z_ff);
                  frac_ff         <= {req_frac_z, req_frac_y, req_frac_x};
                  base_ff         <= req_base_density;
                  base_mat_ff     <= req_base_material;
                  delta_ff        <= req_edit_delta;
                  edit_mat_ff     <= req_edit_material;
                  edit_present_ff <= req_edit_present;
                  state_ff        <= ST_DISPATCH;
               end
            end
            ST_DISPATCH: begin
               res_density_ff  <= '0;
               res_material_ff <= '0;
               res_found_ff    <= 1'b0;
               res_sat_ff      <= 1'b0;
               case (func_ff)
                  FUNC_INT: state_ff <= ST_LOOKUP;
                  FUNC_SPLINE: begin
                     acc_ff      <= '0;
                     best_w_ff   <= '0;
                     best_mat_ff <= '0;
                     found_ff    <= 1'b0;
                     scan_cnt_ff <= '0;
                     state_ff    <= ST_WSETUP;
                  end
                  default: begin
                     done_pend_ff <= 1'b1;
                     state_ff     <= ST_IDLE;
                  end
               endcase
            end
            ST_LOOKUP: begin
               if (!ctr_in || !mem_rdata.present) begin
                  res_density_ff  <= base_ff;
                  res_material_ff <= base_mat_ff;
               end else begin
                  res_density_ff  <= clip16(lk_sum);
                  res_material_ff <= pick_mat(clip16(lk_sum), mem_rdata.material,
                                              base_mat_ff);
                  res_found_ff    <= 1'b1;
                  res_sat_ff      <= is_sat(lk_sum);
               end
               done_pend_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end
            ST_WSETUP: begin
               if (w_done) begin
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               scan_cnt_ff <= scan_cnt_ff + NBR_BITS'(1);
               if (&scan_cnt_ff) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (!(p1_vld_ff || p2_vld_ff || p3_use_ff || p4_use_ff)) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               res_density_ff  <= clip16(fin_sum);
               res_material_ff <= pick_mat(clip16(fin_sum), best_mat_ff, base_mat_ff);
               res_found_ff    <= found_ff;
               res_sat_ff      <= is_sat(fin_sum);
               done_pend_ff    <= 1'b1;
               state_ff        <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready      = (state_ff == ST_IDLE) && !done_pend_ff;
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_density    = rsp_density_ff;
   assign rsp_material   = rsp_material_ff;
   assign rsp_edit_found = rsp_found_ff;
   assign rsp_saturated  = rsp_sat_ff;

   `EBS_ASSERT_IMP(a_no_transfer_while_clearing, state_ff == ST_CLEAR, !req_ready, "request taken during memory clear")
   `EBS_ASSERT_IMP(a_no_write_during_scan, (state_ff == ST_SCAN) || (state_ff == ST_DRAIN), !mem_we, "memory write during neighbor scan")
   `EBS_ASSERT_IMP(a_accumulate_only_in_scan, p4_use_ff, (state_ff == ST_SCAN) || (state_ff == ST_DRAIN), "accumulation outside scan")
   `EBS_ASSERT_NEXT(a_scan_continues, (state_ff == ST_SCAN) && !(&scan_cnt_ff), state_ff == ST_SCAN, "scan ended early")

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the edit overlay B-spline sampler with random handshake timing.
module testbench;
   import ebs_pkg::*;

   localparam logic [1:0] FUNC_UNKNOWN = 2'd3;

   typedef struct {
      logic [1:0]         func;
      logic signed [15:0] cx, cy, cz;
      logic [7:0]         fx, fy, fz;
      logic signed [15:0] base;
      logic [7:0]         bmat;
      logic signed [15:0] delta;
      logic [7:0]         emat;
      logic               pres;
   } sample_req_type;

   typedef struct {
      logic signed [15:0] density;
      logic [7:0]         material;
      logic               found;
      logic               sat;
   } sample_rsp_type;

   typedef longint taps_type[4];

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_ready;
   logic [1:0]         req_func = 0;
   logic signed [15:0] req_coord_x = 0, req_coord_y = 0, req_coord_z = 0;
   logic [7:0]         req_frac_x = 0, req_frac_y = 0, req_frac_z = 0;
   logic signed [15:0] req_base_density = 0;
   logic [7:0]         req_base_material = 0;
   logic signed [15:0] req_edit_delta = 0;
   logic [7:0]         req_edit_material = 0;
   logic               req_edit_present = 0;
   logic               rsp_valid;
   logic               rsp_ready = 0;
   logic signed [15:0] rsp_density;
   logic [7:0]         rsp_material;
   logic               rsp_edit_found;
   logic               rsp_saturated;
   logic               csr_valid = 0;
   logic               csr_ready;
   logic [1:0]         csr_index = 0;
   logic [15:0]        csr_data = 0;

   sample_req_type pending_reqs[$];
   sample_rsp_type expected_samples[$];

   // Predictor copy of the block state.
   int                 model_org_x = 0, model_org_y = 0, model_org_z = 0;
   bit                 cell_present[4096];
   logic signed [15:0] cell_delta[4096];
   logic [7:0]         cell_mat[4096];

   // Origin that the stimulus aims at.
   int stim_org_x, stim_org_y, stim_org_z;

   bit req_taken = 0;
   bit hold_request = 0;
   int hold_left = 0;
   int burst_left = 8;
   int gap_left = 0;
   int stall_mode = 0;
   int stall_phase = 0;
   int mismatches = 0;
   int idle_cycles = 0;

   edit_overlay_bspline_sampler uut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   function automatic int cell_index(int x, int y, int z);
      int rx, ry, rz;
      rx = x - model_org_x;
      ry = y - model_org_y;
      rz = z - model_org_z;
      if (rx < 0 || rx > 15 || ry < 0 || ry > 15 || rz < 0 || rz > 15) return -1;
      return rx | (ry << 4) | (rz << 8);
   endfunction

   function automatic taps_type bspline_taps(logic [7:0] frac);
      taps_type w;
      longint s, u, s3, u2, u3, v;
      longint raw[4];
      s = 256;
      u = frac;
      s3 = s * s * s;
      u2 = u * u;
      u3 = u2 * u;
      v = s - u;
      raw[0] = v * v * v;
      raw[1] = 3 * u3 - 6 * u2 * s + 4 * s3;
      raw[2] = -3 * u3 + 3 * u2 * s + 3 * u * s * s + s3;
      raw[3] = u3;
      for (int i = 0; i < 4; i++) w[i] = (raw[i] * 32768 + 3 * s3) / (6 * s3);
      return w;
   endfunction

   function automatic logic [7:0] pick_material(longint dens, logic [7:0] emat,
                                                logic [7:0] bmat);
      if (dens <= 0) return 8'd0;
      if (emat != 0) return emat;
      return (bmat > 1) ? bmat : 8'd1;
   endfunction

   function automatic sample_rsp_type predict_sample(sample_req_type r);
      sample_rsp_type o;
      int idx;
      longint sum, acc, w, best_w, rnd, y;
      logic [7:0] best_mat;
      bit found;
      taps_type wx, wy, wz;
      o = '{0, 0, 0, 0};
      case (r.func)
         FUNC_WRITE: begin
            idx = cell_index(r.cx, r.cy, r.cz);
            if (idx >= 0) begin
               cell_present[idx] = r.pres;
               cell_delta[idx] = r.pres ? r.delta : 16'sd0;
               cell_mat[idx] = r.pres ? r.emat : 8'd0;
            end
         end
         FUNC_INT: begin
            idx = cell_index(r.cx, r.cy, r.cz);
            if (idx < 0 || !cell_present[idx]) begin
               o.density = r.base;
               o.material = r.bmat;
            end else begin
               sum = longint'(r.base) + longint'(cell_delta[idx]);
               o.sat = (sum > 32767 || sum < -32768);
               if (sum > 32767) sum = 32767;
               if (sum < -32768) sum = -32768;
               o.density = sum[15:0];
               o.material = pick_material(sum, cell_mat[idx], r.bmat);
               o.found = 1;
            end
         end
         FUNC_SPLINE: begin
            wx = bspline_taps(r.fx);
            wy = bspline_taps(r.fy);
            wz = bspline_taps(r.fz);
            acc = 0;
            best_w = 0;
            best_mat = 0;
            found = 0;
            for (int k = 0; k < 4; k++)
               for (int j = 0; j < 4; j++)
                  for (int i = 0; i < 4; i++) begin
                     w = (wx[i] * wy[j] * wz[k] + (longint'(1) << 28)) >>> 29;
                     if (w > WEIGHT_SKIP) begin
                        idx = cell_index(r.cx + i - 1, r.cy + j - 1, r.cz + k - 1);
                        if (idx >= 0 && cell_present[idx]) begin
                           found = 1;
                           acc += longint'(cell_delta[idx]) * w;
                           if (cell_mat[idx] != 0 && w > best_w) begin
                              best_w = w;
                              best_mat = cell_mat[idx];
                           end
                        end
                     end
                  end
            y = acc + 32768;
            rnd = (y >= 0) ? (y >>> 16) : -(((-y) + 65535) >>> 16);
            sum = longint'(r.base) + rnd;
            o.sat = (sum > 32767 || sum < -32768);
            if (sum > 32767) sum = 32767;
            if (sum < -32768) sum = -32768;
            o.density = sum[15:0];
            o.material = pick_material(sum, best_mat, r.bmat);
            o.found = found;
         end
         default: ;
      endcase
      return o;
   endfunction

   function automatic sample_req_type make_req(logic [1:0] func, int ox, int oy, int oz,
         int fx, int fy, int fz, int base, int bmat, int delta, int emat, bit pres);
      sample_req_type r;
      r.func = func;
      r.cx = 16'(stim_org_x + ox);
      r.cy = 16'(stim_org_y + oy);
      r.cz = 16'(stim_org_z + oz);
      r.fx = 8'(fx);
      r.fy = 8'(fy);
      r.fz = 8'(fz);
      r.base = 16'(base);
      r.bmat = 8'(bmat);
      r.delta = 16'(delta);
      r.emat = 8'(emat);
      r.pres = pres;
      return r;
   endfunction

   function automatic int pick_frac();
      case ($urandom_range(7, 0))
         0: return 0;
         1: return 255;
         2: return 128;
         default: return $urandom_range(255, 0);
      endcase
   endfunction

   function automatic int pick_delta();
      case ($urandom_range(5, 0))
         0: return $urandom_range(1, 0) ? 32767 : -32768;
         1: return $urandom_range(65535, 0);
         default: return $urandom_range(2048, 0) - 1024;
      endcase
   endfunction

   function automatic sample_req_type random_req();
      sample_req_type r;
      int sel, lo, hi;
      logic [1:0] func;
      sel = $urandom_range(99, 0);
      func = sel < 35 ? FUNC_WRITE : sel < 60 ? FUNC_INT : sel < 95 ? FUNC_SPLINE
                                                                    : FUNC_UNKNOWN;
      lo = (func == FUNC_SPLINE) ? -3 : -2;
      hi = (func == FUNC_SPLINE) ? 18 : 17;
      r = make_req(func, $urandom_range(hi - lo, 0) + lo, $urandom_range(hi - lo, 0) + lo,
                   $urandom_range(hi - lo, 0) + lo, pick_frac(), pick_frac(), pick_frac(),
                   $urandom_range(3, 0) == 0 ? $urandom_range(65535, 0)
                                             : $urandom_range(4096, 0) - 2048,
                   $urandom_range(255, 0), pick_delta(),
                   $urandom_range(2, 0) == 0 ? 0 : $urandom_range(255, 0),
                   $urandom_range(5, 0) != 0);
      if ($urandom_range(15, 0) == 0) begin
         r.cx = 16'($urandom_range(65535, 0));
         r.cy = 16'($urandom_range(65535, 0));
         r.cz = 16'($urandom_range(65535, 0));
      end
      return r;
   endfunction

   task automatic write_origin(csr_index_type index, int value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= 16'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_valid || expected_samples.size() != 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   // Request driver: bursts of transfers separated by random gaps.
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_taken) begin
            req_valid <= 1'b1;
         end else if (gap_left > 0) begin
            req_valid <= 1'b0;
            gap_left--;
         end else if (pending_reqs.size() > 0) begin
            sample_req_type r;
            r = pending_reqs.pop_front();
            req_valid <= 1'b1;
            req_func <= r.func;
            req_coord_x <= r.cx;
            req_coord_y <= r.cy;
            req_coord_z <= r.cz;
            req_frac_x <= r.fx;
            req_frac_y <= r.fy;
            req_frac_z <= r.fz;
            req_base_density <= r.base;
            req_base_material <= r.bmat;
            req_edit_delta <= r.delta;
            req_edit_material <= r.emat;
            req_edit_present <= r.pres;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(30, 1);
               gap_left = $urandom_range(2, 0) == 0 ? 0 : $urandom_range(20, 1);
            end
         end else begin
            req_valid <= 1'b0;
         end
         req_taken = 0;
      end
   end

   // Response receiver with its own stall pattern and a single long hold-off.
   always @(negedge clock) begin
      if (hold_request) begin
         hold_request = 0;
         hold_left = 400;
      end
      stall_phase++;
      if (stall_phase >= 200) begin
         stall_phase = 0;
         stall_mode = $urandom_range(2, 0);
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(1, 0));
            default: rsp_ready <= ($urandom_range(3, 0) == 0);
         endcase
      end
   end

   // Monitor: tracks origin writes, predicts on every request transfer and checks every response transfer.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ORIGIN_X: model_org_x = int'(signed'(csr_data));
               CSR_ORIGIN_Y: model_org_y = int'(signed'(csr_data));
               CSR_ORIGIN_Z: model_org_z = int'(signed'(csr_data));
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            sample_req_type r;
            r = '{req_func, req_coord_x, req_coord_y, req_coord_z, req_frac_x, req_frac_y,
                  req_frac_z, req_base_density, req_base_material, req_edit_delta,
                  req_edit_material, req_edit_present};
            expected_samples.push_back(predict_sample(r));
            req_taken = 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_samples.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("Response transfer with nothing expected.");
            end else begin
               sample_rsp_type e;
               e = expected_samples.pop_front();
               if (rsp_density !== e.density || rsp_material !== e.material ||
                   rsp_edit_found !== e.found || rsp_saturated !== e.sat) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"Expected density %0d material %0d found %0b sat %0b,",
                               " got %0d %0d %0b %0b."},
                              e.density, e.material, e.found, e.sat, rsp_density,
                              rsp_material, rsp_edit_found, rsp_saturated);
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= 20000) begin
            $display("edit_overlay_bspline_sampler: mismatch");
            $finish;
         end
      end
   end

   initial begin
      int origins[6][3];
      origins = '{'{0, 0, 0}, '{-32768, -32768, -32768}, '{32767, 32767, 32767},
                  '{32760, -5, 100}, '{0, 0, 0}, '{0, 0, 0}};
      for (int p = 4; p < 6; p++)
         for (int a = 0; a < 3; a++) origins[p][a] = $urandom_range(65535, 0) - 32768;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      for (int p = 0; p < 6; p++) begin
         if (p > 0) wait_drained();
         stim_org_x = origins[p][0];
         stim_org_y = origins[p][1];
         stim_org_z = origins[p][2];
         write_origin(CSR_ORIGIN_X, stim_org_x);
         write_origin(CSR_ORIGIN_Y, stim_org_y);
         write_origin(CSR_ORIGIN_Z, stim_org_z);
         if (p == 0) begin
            pending_reqs.push_back(make_req(FUNC_WRITE, 0, 0, 0, 0, 0, 0, 0, 0, 32767, 255, 1));
            pending_reqs.push_back(make_req(FUNC_WRITE, 15, 15, 15, 0, 0, 0, 0, 0, -32768, 0, 1));
            pending_reqs.push_back(make_req(FUNC_WRITE, 16, 0, 0, 0, 0, 0, 0, 0, 500, 7, 1));
            pending_reqs.push_back(make_req(FUNC_WRITE, 5, 5, 5, 0, 0, 0, 0, 0, 256, 9, 1));
            pending_reqs.push_back(make_req(FUNC_WRITE, 6, 5, 5, 0, 0, 0, 0, 0, 256, 4, 1));
            pending_reqs.push_back(make_req(FUNC_INT, 0, 0, 0, 0, 0, 0, 32767, 3, 0, 0, 0));
            pending_reqs.push_back(make_req(FUNC_INT, 15, 15, 15, 0, 0, 0, -32768, 200, 0, 0, 0));
            pending_reqs.push_back(make_req(FUNC_INT, 15, 15, 15, 0, 0, 0, 32767, 0, 0, 0, 0));
            pending_reqs.push_back(make_req(FUNC_INT, 16, 0, 0, 0, 0, 0, 100, 12, 0, 0, 0));
            pending_reqs.push_back(make_req(FUNC_INT, -1, 0, 0, 0, 0, 0, -100, 12, 0, 0, 0));
            pending_reqs.push_back(make_req(FUNC_INT, 3, 3, 3, 0, 0, 0, 5, 0, 0, 0, 0));
            pending_reqs.push_back(make_req(FUNC_SPLINE, 5, 5, 5, 128, 0, 0, 10, 0, 0, 0, 0));
            pending_reqs.push_back(make_req(FUNC_SPLINE, 5, 5, 5, 0, 0, 0, -9000, 1, 0, 0, 0));
            pending_reqs.push_back(make_req(FUNC_SPLINE, 0, 0, 0, 255, 255, 255, 32767, 0, 0, 0, 0));
            pending_reqs.push_back(make_req(FUNC_SPLINE, 15, 15, 15, 255, 1, 128, -32768, 0, 0, 0, 0));
            pending_reqs.push_back(make_req(FUNC_SPLINE, 9, 9, 9, 77, 33, 200, 300, 0, 0, 0, 0));
            pending_reqs.push_back(make_req(FUNC_UNKNOWN, 0, 0, 0, 255, 255, 255, 32767, 255, -1, 255, 1));
            pending_reqs.push_back(make_req(FUNC_WRITE, 0, 0, 0, 0, 0, 0, 0, 0, 1234, 55, 0));
            pending_reqs.push_back(make_req(FUNC_INT, 0, 0, 0, 0, 0, 0, 7, 0, 0, 0, 0));
            pending_reqs.push_back(make_req(FUNC_SPLINE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
         end
         if (p == 2) hold_request = 1;
         for (int n = 0; n < 285; n++) pending_reqs.push_back(random_req());
      end
      wait_drained();
      if (mismatches == 0)
         $display("edit_overlay_bspline_sampler: match");
      else
         $display("edit_overlay_bspline_sampler: mismatch");
      $finish;
   end

endmodule
